@@ rtl/core/flm_pkg.sv @@
package flm_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int MAX_LINE    = 8192;
   localparam int LEN_W       = $clog2(MAX_LINE + 1);
   localparam int PLEN_W      = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] UPPER_A      = 8'h41;
   localparam logic [7:0] UPPER_Z      = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   typedef enum logic [2:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_FOLD_CASE      = 3'd3,
      CSR_FIRST_ONLY     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [63:0]       pattern_high;
      logic [63:0]       pattern_low;
      logic [PLEN_W-1:0] pattern_length;
      logic              fold_case;
   } match_cfg_type;

   typedef struct packed {
      logic hit;
      logic eos;
   } line_event_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold);
      if (fold && c >= UPPER_A && c <= UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

@@ rtl/core/fixed_string_line_matcher.sv @@
// Reports for the lines of a byte stream whether a fixed pattern of one to
// sixteen bytes occurs in it, together with a saturating count of matching lines.
// The req channel takes one text byte per item; req_tlast marks the final byte.
// A line closes on a newline, at the maximum line length, or at the final byte.
// Each closed line gives one rsp item, but in first-only mode the lines after the
// first matching line give none until the one closing the stream. That item has
// rsp_tlast set, after which the count and the first-only state are cleared.
// The csr port writes the pattern, its length and the mode bits; the user must do
// so only while idle, since the block itself does not enforce this.
// One byte is accepted per cycle while the event queue is not full; the window
// compare of all sixteen positions is done in the cycle the byte is accepted.
// A result passes through the event queue, then the output register. When rsp_tready
// is low, the output register holds and the two-entry event queue fills; req_tready
// falls once the queue is full. Reset clears the window, the line state, the count and
// the configuration (pattern length one, both modes off).
module fixed_string_line_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] line_matched, [32:1] matching_lines, zero fill
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   flm_pkg::match_cfg_type  cfg_ff;
   logic                    first_only_ff;
   logic                    push, queue_full, head_valid, pop;
   flm_pkg::line_event_type push_event, head_event;
   logic                    out_matched;
   logic [31:0]             out_total;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.pattern_length <= flm_pkg::PLEN_W'(1);
         cfg_ff.fold_case      <= 1'b0;
         first_only_ff         <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            flm_pkg::CSR_PATTERN_LOW:    cfg_ff.pattern_low <= csr_wdata;
            flm_pkg::CSR_PATTERN_HIGH:   cfg_ff.pattern_high <= csr_wdata;
            flm_pkg::CSR_PATTERN_LENGTH: cfg_ff.pattern_length <= csr_wdata[flm_pkg::PLEN_W-1:0];
            flm_pkg::CSR_FOLD_CASE:      cfg_ff.fold_case <= csr_wdata[0];
            flm_pkg::CSR_FIRST_ONLY:     first_only_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   flm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_eos     (req_tlast),
      .in_ready   (req_tready),
      .queue_full (queue_full),
      .push       (push),
      .push_event (push_event)
   );

   flm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_event (head_event)
   );

   flm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .first_only  (first_only_ff),
      .head_valid  (head_valid),
      .head_event  (head_event),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_matched (out_matched),
      .out_total   (out_total),
      .out_done    (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, out_total, out_matched};

endmodule

@@ rtl/core/flm_front.sv @@
module flm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  flm_pkg::match_cfg_type cfg,
   input  logic                  in_valid,
   input  logic [7:0]            in_byte,
   input  logic                  in_eos,
   output logic                  in_ready,
   input  logic                  queue_full,
   output logic                  push,
   output flm_pkg::line_event_type push_event
);

   logic [7:0]               window_ff [flm_pkg::MAX_PATTERN];
   logic [7:0]               window_in [flm_pkg::MAX_PATTERN];
   logic [flm_pkg::LEN_W-1:0] length_ff, length_in, length_next;
   logic                     line_hit_ff, line_hit_in;
   logic [flm_pkg::PLEN_W-1:0] eff_len;
   logic [127:0]             pattern;
   logic [flm_pkg::MAX_PATTERN-1:0] byte_ok;
   logic                     is_newline, window_hit, hit_now, close, accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign pattern  = {cfg.pattern_high, cfg.pattern_low};
   assign is_newline = (in_byte == flm_pkg::NEWLINE_BYTE);

   always_comb begin
      if (cfg.pattern_length == '0) begin
         eff_len = flm_pkg::PLEN_W'(1);
      end else if (cfg.pattern_length > flm_pkg::PLEN_W'(flm_pkg::MAX_PATTERN)) begin
         eff_len = flm_pkg::PLEN_W'(flm_pkg::MAX_PATTERN);
      end else begin
         eff_len = cfg.pattern_length;
      end
   end

   always_comb begin
      window_in[0] = in_byte;
      for (int i = 1; i < flm_pkg::MAX_PATTERN; i++) begin
         window_in[i] = window_ff[i-1];
      end
      length_next = (length_ff < flm_pkg::LEN_W'(flm_pkg::MAX_LINE)) ?
                    length_ff + flm_pkg::LEN_W'(1) : length_ff;
   end

   always_comb begin
      logic [flm_pkg::PLEN_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < flm_pkg::MAX_PATTERN; i++) begin
         idx = eff_len - flm_pkg::PLEN_W'(1) - flm_pkg::PLEN_W'(i);
         if (flm_pkg::PLEN_W'(i) < eff_len) begin
            byte_ok[i] = flm_pkg::fold_byte(window_in[i], cfg.fold_case) ==
                         flm_pkg::fold_byte(pattern[{idx[3:0], 3'b000} +: 8], cfg.fold_case);
         end else begin
            byte_ok[i] = 1'b1;
         end
      end
      window_hit = (&byte_ok) && (length_next >= flm_pkg::LEN_W'(eff_len));
   end

   always_comb begin
      hit_now = line_hit_ff || (!is_newline && window_hit);
      close   = is_newline || in_eos ||
                (length_next >= flm_pkg::LEN_W'(flm_pkg::MAX_LINE));
      push           = accept && close;
      push_event.hit = hit_now;
      push_event.eos = in_eos;
      if (close) begin
         line_hit_in = 1'b0;
         length_in   = '0;
      end else begin
         line_hit_in = hit_now;
         length_in   = length_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         line_hit_ff <= 1'b0;
         for (int i = 0; i < flm_pkg::MAX_PATTERN; i++) begin
            window_ff[i] <= '0;
         end
      end else if (accept) begin
         length_ff   <= length_in;
         line_hit_ff <= line_hit_in;
         if (!is_newline) begin
            for (int i = 0; i < flm_pkg::MAX_PATTERN; i++) begin
               window_ff[i] <= window_in[i];
            end
         end
      end
   end

endmodule

@@ rtl/core/flm_queue.sv @@
module flm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  flm_pkg::line_event_type push_event,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output flm_pkg::line_event_type head_event
);

   localparam int PTR_W = $clog2(flm_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(flm_pkg::QUEUE_DEPTH + 1);

   flm_pkg::line_event_type entry_ff [flm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(flm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_event = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(flm_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(flm_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

@@ rtl/core/flm_back.sv @@
module flm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   first_only,
   input  logic                   head_valid,
   input  flm_pkg::line_event_type head_event,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_matched,
   output logic [31:0]            out_total,
   output logic                   out_done
);

   logic [31:0] total_ff, total_in, total_next;
   logic        stopped_ff, stopped_in;
   logic        valid_ff, valid_in;
   logic        matched_ff, done_ff;
   logic [31:0] result_total_ff;
   logic        hit, emit;

   assign pop         = head_valid && (!valid_ff || out_ready);
   assign out_valid   = valid_ff;
   assign out_matched = matched_ff;
   assign out_total   = result_total_ff;
   assign out_done    = done_ff;

   always_comb begin
      hit        = head_event.hit && !stopped_ff;
      total_next = (hit && total_ff != 32'hFFFF_FFFF) ? total_ff + 32'd1 : total_ff;
      emit       = !stopped_ff || head_event.eos;
      total_in   = total_ff;
      stopped_in = stopped_ff;
      valid_in   = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         if (head_event.eos) begin
            total_in   = '0;
            stopped_in = 1'b0;
         end else begin
            total_in   = total_next;
            stopped_in = stopped_ff || (hit && first_only);
         end
         if (emit) begin
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         stopped_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         total_ff   <= total_in;
         stopped_ff <= stopped_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         matched_ff      <= hit;
         result_total_ff <= total_next;
         done_ff         <= head_event.eos;
      end
   end

endmodule
